>>> hdl/fdre_pkg.sv
package fdre_pkg;

  localparam int unsigned FRAME_WORDS = 1048576;
  localparam int unsigned POS_W       = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_WORDS - 1);

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned RUN_W   = 23;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned SLOTS   = 4;

  localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_COMPARE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    TAG_RUN_START = 2'd0,
    TAG_WORD      = 2'd1,
    TAG_RUN_LEN   = 2'd2,
    TAG_TOTAL     = 2'd3
  } tag_e;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] pixel_word;
    logic              last_of_frame;
  } in_req_t;

  typedef struct packed {
    tag_e              tag;
    logic [WORD_W-1:0] value;
    logic              last;
  } out_rsp_t;

  typedef struct packed {
    logic               in_run;
    logic [RUN_W-1:0]   run_bytes;
    logic [TOTAL_W-1:0] total;
  } enc_state_t;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] ref_word;
    logic [POS_W-1:0]  pos;
    logic              frame_end;
  } enc_item_t;

  typedef struct packed {
    logic [2:0]             count;
    out_rsp_t [SLOTS-1:0]   slot;
    enc_state_t             next;
  } enc_result_t;

endpackage

>>> hdl/fdre_encode.sv
module fdre_encode import fdre_pkg::*; (
  input  enc_item_t   item_i,
  input  enc_state_t  state_i,
  output enc_result_t result_o
);

  logic             diff;
  logic             open_run;
  logic [RUN_W-1:0] rb_base;
  logic [RUN_W:0]   rb_sum;
  logic [RUN_W-1:0] rb_after;
  logic [TOTAL_W:0] tot_sum;
  logic [TOTAL_W-1:0] tot_mid;
  logic [2:0]       n;

  always_comb begin
    result_o = '0;
    n        = 3'd0;
    diff     = (item_i.kind == KIND_COMPARE) && (item_i.ref_word != item_i.word);
    open_run = diff && !state_i.in_run;
    rb_base  = open_run ? '0 : state_i.run_bytes;
    rb_sum   = {1'b0, rb_base} + (RUN_W+1)'(4);
    rb_after = rb_sum[RUN_W] ? RUN_MAX : rb_sum[RUN_W-1:0];
    tot_sum  = {1'b0, state_i.total} + (TOTAL_W+1)'({open_run, diff, 2'b00});
    tot_mid  = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

    if (item_i.kind == KIND_COMPARE) begin
      if (open_run) begin
        result_o.slot[n[1:0]].tag   = TAG_RUN_START;
        result_o.slot[n[1:0]].value = WORD_W'({item_i.pos, 2'b00});
        n = n + 3'd1;
      end
      if (diff) begin
        result_o.slot[n[1:0]].tag   = TAG_WORD;
        result_o.slot[n[1:0]].value = item_i.word;
        n = n + 3'd1;
      end else if (state_i.in_run) begin
        result_o.slot[n[1:0]].tag   = TAG_RUN_LEN;
        result_o.slot[n[1:0]].value = WORD_W'(state_i.run_bytes);
        n = n + 3'd1;
      end
      if (item_i.frame_end) begin
        if (diff) begin
          result_o.slot[n[1:0]].tag   = TAG_RUN_LEN;
          result_o.slot[n[1:0]].value = WORD_W'(rb_after);
          n = n + 3'd1;
        end
        result_o.slot[n[1:0]].tag   = TAG_TOTAL;
        result_o.slot[n[1:0]].value = tot_mid;
        n = n + 3'd1;
      end else begin
        result_o.next.in_run    = diff;
        result_o.next.run_bytes = diff ? rb_after : '0;
        result_o.next.total     = tot_mid;
      end
    end
    result_o.count = n;
  end

endmodule

>>> hdl/frame_delta_run_encoder_core.sv
// Items are registered in the compare stage with their old reference words, and results
// in the single output register. While the output is not stalled, one result is sent per
// cycle, and one item per cycle is taken while each item yields at most one result.
// Reset clears position, run state, running total and all valid flags at once. The
// reference memory is not cleared and holds undefined words until they are loaded.
module frame_delta_run_encoder_core import fdre_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  logic [WORD_W-1:0] ref_mem [FRAME_WORDS];
  logic [WORD_W-1:0] ref_rd_q;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             in_frame_end;
  logic             accept;

  logic             s1_valid_q, s1_valid_d;
  kind_e            s1_kind_q;
  logic [WORD_W-1:0] s1_word_q;
  logic [POS_W-1:0] s1_pos_q;
  logic             s1_end_q;
  logic             s1_done;

  enc_state_t  state_q, state_d;
  enc_item_t   item;
  enc_result_t res;

  logic [1:0] idx_q, idx_d;
  logic       last_slot;
  logic       push;
  logic       out_valid_q, out_valid_d;
  out_rsp_t   out_rsp_q;

  assign accept       = in_valid_i && in_ready_o;
  assign in_frame_end = in_req_i.last_of_frame || (pos_q == POS_LAST);
  assign pos_d        = in_frame_end ? '0 : pos_q + POS_W'(1);

  // Read-first port: the old word is captured while the new word is stored.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ref_rd_q         <= ref_mem[pos_q];
      ref_mem[pos_q]   <= in_req_i.pixel_word;
    end
  end

  assign item = '{kind:      s1_kind_q,
                  word:      s1_word_q,
                  ref_word:  ref_rd_q,
                  pos:       s1_pos_q,
                  frame_end: s1_end_q};

  fdre_encode u_encode (
    .item_i   (item),
    .state_i  (state_q),
    .result_o (res)
  );

  assign last_slot = ({1'b0, idx_q} == (res.count - 3'd1));

  always_comb begin
    push        = s1_valid_q && (res.count != 3'd0) && (!out_valid_q || out_ready_i);
    s1_done     = s1_valid_q &&
                  ((res.count == 3'd0) || (push && last_slot));
    in_ready_o  = !s1_valid_q || s1_done;
    s1_valid_d  = accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_q);
    state_d     = s1_done ? res.next : state_q;
    idx_d       = s1_done ? 2'd0 : (push ? idx_q + 2'd1 : idx_q);
    out_valid_d = push ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      state_q     <= '0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
      end
      s1_valid_q  <= s1_valid_d;
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= in_req_i.kind;
      s1_word_q <= in_req_i.pixel_word;
      s1_pos_q  <= pos_q;
      s1_end_q  <= in_frame_end;
    end
    if (push) begin
      out_rsp_q <= '{tag:   res.slot[idx_q].tag,
                     value: res.slot[idx_q].value,
                     last:  last_slot};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_run_bytes_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.in_run == (state_q.run_bytes != '0))
    else $error("run byte count disagrees with open run flag");

  a_idx_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> s1_valid_q)
    else $error("result index advanced without a pending item");

  a_load_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_kind_q == KIND_LOAD)) |-> (s1_done && !push))
    else $error("load item did not retire silently");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (s1_valid_q && (idx_q == 2'd0)))
    else $error("accepted request missing from compare stage");
`endif

endmodule

>>> test/frame_delta_run_encoder_core_tb.sv
`timescale 1ns / 1ps

module frame_delta_run_encoder_core_tb;
  import fdre_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 210;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] word;
    logic              mark;
    logic              typed;
    logic [2:0]        n_want;
    out_rsp_t [3:0]    want;
  } stim_row_t;

  localparam out_rsp_t NO_TOKEN = '0;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_rsp;

  logic [WORD_W-1:0]  ref_mem [FRAME_WORDS];
  logic [POS_W-1:0]   cur_pos;
  logic               run_open;
  logic [RUN_W-1:0]   run_len;
  logic [TOTAL_W-1:0] frame_bytes;

  out_rsp_t    step_tok [4];
  out_rsp_t    pending_tokens [$];
  stim_row_t   stim_rows [$];
  out_rsp_t    due_tok;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  logic        calm;
  logic        hold_req;
  logic        held;

  frame_delta_run_encoder_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_rsp_t rs(tag_e t, logic [WORD_W-1:0] v, logic l);
    return '{tag: t, value: v, last: l};
  endfunction

  function automatic logic [TOTAL_W-1:0] add_sat32(logic [TOTAL_W-1:0] x,
                                                   logic [TOTAL_W-1:0] n);
    if (x > TOTAL_MAX - n) return TOTAL_MAX;
    return x + n;
  endfunction

  function automatic int encode_word(in_req_t r);
    tag_e              tags [4];
    logic [WORD_W-1:0] vals [4];
    int                n;
    logic [POS_W-1:0]  p;
    logic              fend;
    n = 0;
    p = cur_pos;
    fend = r.last_of_frame || (p == POS_LAST);
    if (r.kind == KIND_LOAD) begin
      ref_mem[p] = r.pixel_word;
      run_open = 1'b0;
      run_len = '0;
      frame_bytes = '0;
      cur_pos = fend ? '0 : p + 1'b1;
      return 0;
    end
    if (ref_mem[p] != r.pixel_word) begin
      if (!run_open) begin
        tags[n] = TAG_RUN_START;
        vals[n] = WORD_W'({p, 2'b00});
        n++;
        run_open = 1'b1;
        run_len = '0;
        frame_bytes = add_sat32(frame_bytes, 8);
      end
      ref_mem[p] = r.pixel_word;
      tags[n] = TAG_WORD;
      vals[n] = r.pixel_word;
      n++;
      run_len = (run_len > RUN_MAX - 4) ? RUN_MAX : RUN_W'(run_len + 4);
      frame_bytes = add_sat32(frame_bytes, 4);
    end else if (run_open) begin
      tags[n] = TAG_RUN_LEN;
      vals[n] = WORD_W'(run_len);
      n++;
      run_open = 1'b0;
      run_len = '0;
    end
    if (fend) begin
      if (run_open) begin
        tags[n] = TAG_RUN_LEN;
        vals[n] = WORD_W'(run_len);
        n++;
        run_open = 1'b0;
        run_len = '0;
      end
      tags[n] = TAG_TOTAL;
      vals[n] = frame_bytes;
      n++;
      frame_bytes = '0;
      cur_pos = '0;
    end else begin
      cur_pos = p + 1'b1;
    end
    for (int i = 0; i < n; i++) step_tok[i] = rs(tags[i], vals[i], i == n - 1);
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word(int unsigned eq_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < eq_pct) return ref_mem[cur_pos];
    r = $urandom_range(99);
    if (r < 40) return ref_mem[cur_pos] ^ (32'd1 << $urandom_range(31));
    if (r < 50) return '0;
    if (r < 60) return '1;
    return $urandom;
  endfunction

  task automatic add_row(kind_e k, logic [WORD_W-1:0] w, logic m, logic t, logic [2:0] n,
                         out_rsp_t a, out_rsp_t b, out_rsp_t c, out_rsp_t d);
    stim_row_t r;
    r.kind = k;
    r.word = w;
    r.mark = m;
    r.typed = t;
    r.n_want = n;
    r.want = {d, c, b, a};
    stim_rows.push_back(r);
  endtask

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s differs, got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic issue(kind_e k, logic [WORD_W-1:0] w, logic m, logic typed,
                       logic [2:0] n_want, out_rsp_t [3:0] want);
    int                n;
    kind_e             k_use;
    logic [WORD_W-1:0] w_use;
    k_use = k;
    w_use = w;
    // A compare may only meet a reference word that has been loaded.
    if (k == KIND_COMPARE && $isunknown(ref_mem[cur_pos])) begin
      k_use = KIND_LOAD;
      w_use = $urandom;
    end
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= '{kind: k_use, pixel_word: w_use, last_of_frame: m};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = encode_word(in_req);
    items_sent++;
    if (typed) begin
      for (int i = 0; i < n_want; i++) pending_tokens.push_back(want[i]);
    end else begin
      for (int i = 0; i < n; i++) pending_tokens.push_back(step_tok[i]);
    end
    @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        note_mismatch("token with nothing pending", out_rsp.value, '0);
      end else begin
        due_tok = pending_tokens.pop_front();
        if (out_rsp.tag != due_tok.tag) begin
          note_mismatch("tag", 32'(out_rsp.tag), 32'(due_tok.tag));
        end
        if (out_rsp.value != due_tok.value) begin
          note_mismatch("value", out_rsp.value, due_tok.value);
        end
        if (out_rsp.last != due_tok.last) begin
          note_mismatch("last", 32'(out_rsp.last), 32'(due_tok.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("frame_delta_run_encoder_core: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    int unsigned len;
    int unsigned eq_pct;
    int unsigned pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    cur_pos = '0;
    run_open = 1'b0;
    run_len = '0;
    frame_bytes = '0;

    add_row(KIND_LOAD, 32'h0000_0000, 1'b0, 1'b1, 3'd0, NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_LOAD, 32'hFFFF_FFFF, 1'b0, 1'b1, 3'd0, NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_LOAD, 32'hA5A5_A5A5, 1'b0, 1'b1, 3'd0, NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_LOAD, 32'h5A5A_5A5A, 1'b1, 1'b1, 3'd0, NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h0000_0000, 1'b0, 1'b1, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'hFFFF_FFFF, 1'b0, 1'b1, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'hA5A5_A5A5, 1'b0, 1'b1, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h5A5A_5A5A, 1'b1, 1'b1, 3'd1,
            rs(TAG_TOTAL, 32'd0, 1'b1), NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'hFFFF_FFFF, 1'b0, 1'b1, 3'd2,
            rs(TAG_RUN_START, 32'd0, 1'b0), rs(TAG_WORD, 32'hFFFF_FFFF, 1'b1),
            NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h0000_0000, 1'b0, 1'b1, 3'd1,
            rs(TAG_WORD, 32'h0000_0000, 1'b1), NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'hA5A5_A5A5, 1'b0, 1'b1, 3'd1,
            rs(TAG_RUN_LEN, 32'd8, 1'b1), NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h1234_5678, 1'b1, 1'b1, 3'd4,
            rs(TAG_RUN_START, 32'd12, 1'b0), rs(TAG_WORD, 32'h1234_5678, 1'b0),
            rs(TAG_RUN_LEN, 32'd4, 1'b0), rs(TAG_TOTAL, 32'd28, 1'b1));
    add_row(KIND_COMPARE, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h0000_0001, 1'b0, 1'b0, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_LOAD, 32'h0000_0000, 1'b0, 1'b0, 3'd0, NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h0000_0000, 1'b1, 1'b0, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h0000_0000, 1'b1, 1'b0, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_LOAD, 32'hDEAD_BEEF, 1'b1, 1'b0, 3'd0, NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'hDEAD_BEEF, 1'b1, 1'b1, 3'd1,
            rs(TAG_TOTAL, 32'd0, 1'b1), NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h8000_0001, 1'b0, 1'b0, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h7FFF_FFFE, 1'b0, 1'b0, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h0000_0000, 1'b1, 1'b0, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);
    add_row(KIND_COMPARE, 32'h0000_0000, 1'b0, 1'b0, 3'd0,
            NO_TOKEN, NO_TOKEN, NO_TOKEN, NO_TOKEN);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      issue(stim_rows[i].kind, stim_rows[i].word, stim_rows[i].mark, stim_rows[i].typed,
            stim_rows[i].n_want, stim_rows[i].want);
    end

    base = items_sent;
    hold_req = 1'b1;
    while (items_sent - base < RANDOM_ITEMS) begin
      calm = (items_sent - base >= 100) && (items_sent - base < 160);
      pick = $urandom_range(99);
      len = $urandom_range(1, 10);
      eq_pct = $urandom_range(10, 80);
      if (pick < 75) begin
        for (int i = 0; i < len; i++) begin
          issue(KIND_COMPARE, pick_word(eq_pct), i == len - 1, 1'b0, 3'd0, '0);
        end
      end else if (pick < 85) begin
        for (int i = 0; i < len; i++) begin
          issue(KIND_LOAD, $urandom, i == len - 1, 1'b0, 3'd0, '0);
        end
      end else if (pick < 93) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          issue(KIND_COMPARE, pick_word(eq_pct), 1'b0, 1'b0, 3'd0, '0);
        end
      end else begin
        issue(kind_e'($urandom_range(1)), $urandom, 1'($urandom_range(1)), 1'b0, 3'd0, '0);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("frame_delta_run_encoder_core: match");
    end else begin
      $display("frame_delta_run_encoder_core: mismatch");
    end
    $finish;
  end

endmodule
